>>> sv/smds_pkg.sv
// shared types, codes and defaults for the sparse matrix default store
package smds_pkg;

    localparam int SMDS_CAPACITY = 64;
    localparam int ROW_W         = 16;
    localparam int COL_W         = 16;
    localparam int VAL_W         = 32;
    localparam int CNT_W         = 7;

    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_BOUNDS = 2'd3;

    typedef struct packed {
        logic [1:0]              action;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic                    found;
        logic                    status;
        logic [ROW_W-1:0]        row_high;
        logic [ROW_W-1:0]        row_low;
        logic [COL_W-1:0]        col_high;
        logic [COL_W-1:0]        col_low;
        logic [CNT_W-1:0]        entry_count;
    } t_rsp;

    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    // one scanned entry as seen by the compare unit
    typedef struct packed {
        logic   pv;
        logic   valid;
        t_entry entry;
    } t_stream;

    // scan results gathered over the table
    typedef struct packed {
        logic                    hit;
        logic                    any;
        logic                    free_ok;
        logic signed [VAL_W-1:0] hit_value;
        logic [ROW_W-1:0]        rhi;
        logic [ROW_W-1:0]        rlo;
        logic [COL_W-1:0]        chi;
        logic [COL_W-1:0]        clo;
    } t_acc;

endpackage

>>> sv/sparse_matrix_default_store_top.sv
// top level of the sparse matrix default store: sequencer, valid bits, config port
//
//   channel   direction  handshake                      payload
//   request   in         start high while busy low      i_req (t_req)
//   result    out        o_done high for one cycle      o_rsp (t_rsp)
//   config    in/out     apb, psel+penable+pwrite       pwdata / prdata, reg 0 default
//
// read, write and bounds requests scan the whole entry memory through its single
// read port: o_done rises once the SCAN, FLUSH and DONE states have passed, busy falls with it,
// so the next request is taken at the earliest while o_done is high
// clear takes effect at the accept edge and its result follows in the next cycle
// reset is synchronous active low; it empties the table and sets the default to 0
// the result is shown for one cycle only; the receiver has no way to stall it
module sparse_matrix_default_store_top import smds_pkg::*; #(
    parameter int CAPACITY = SMDS_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // sequencer codes
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]          r_state;
    t_req                r_req;
    logic [IW-1:0]       r_addr;
    logic                r_pv;
    logic                r_pvalid;
    logic [IW-1:0]       r_pidx;
    logic [CAPACITY-1:0] r_valid;
    logic [CW-1:0]       r_count;
    logic [VAL_W-1:0]    r_default;
    logic                r_done;
    t_rsp                r_rsp;

    logic                w_accept;
    logic                w_cfg_wr;
    t_entry              w_wdata;
    t_entry              w_rdata;
    t_stream             w_str;
    t_acc                w_acc;
    logic [IW-1:0]       w_hit_idx;
    logic [IW-1:0]       w_free_idx;

    // finishing step of a request
    t_rsp                n_rsp;
    logic [CW-1:0]       n_count;
    logic                w_we;
    logic [IW-1:0]       w_waddr;
    logic                w_vset;
    logic                w_vclr;
    logic [CW+CNT_W-1:0] w_cnt_ext;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    // config register: only the default value, at byte addresses 0 to 3
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata   = paddr[2] ? 32'd0 : r_default;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= '0;
        end else if (w_cfg_wr) begin
            r_default <= pwdata;
        end
    end

    // entry memory and compare unit
    assign w_wdata = '{row: r_req.row, col: r_req.col, value: r_req.value};

    smds_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_str = '{pv: r_pv, valid: r_pvalid, entry: w_rdata};

    smds_scan #(
        .IW (IW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (w_accept),
        .i_row      (r_req.row),
        .i_col      (r_req.col),
        .i_str      (w_str),
        .i_idx      (r_pidx),
        .o_acc      (w_acc),
        .o_hit_idx  (w_hit_idx),
        .o_free_idx (w_free_idx)
    );

    // sequencer: walk the table one address a cycle, then drain the read pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_pv <= 1'b0;
                    if (w_accept && i_req.action != ACT_CLEAR) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pv <= 1'b1;
                    if (r_addr == IW'(CAPACITY - 1)) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_pv    <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_pv    <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_pv    <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // address and pipe payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_req;
            r_addr <= '0;
        end else if (r_state == S_SCAN) begin
            r_addr <= r_addr + IW'(1);
        end
        r_pvalid <= r_valid[r_addr];
        r_pidx   <= r_addr;
    end

    // result and table update once the scan is complete
    always_comb begin
        n_rsp   = '0;
        n_count = r_count;
        w_we    = 1'b0;
        w_waddr = w_hit_idx;
        w_vset  = 1'b0;
        w_vclr  = 1'b0;
        case (r_req.action)
            ACT_READ: begin
                n_rsp.found      = w_acc.hit;
                n_rsp.read_value = w_acc.hit ? w_acc.hit_value : r_default;
            end
            ACT_WRITE: begin
                if (w_acc.hit) begin
                    if (r_req.value == r_default) begin
                        w_vclr  = 1'b1;
                        n_count = r_count - CW'(1);
                    end else begin
                        w_we = 1'b1;
                    end
                end else if (r_req.value != r_default) begin
                    if (w_acc.free_ok) begin
                        w_we    = 1'b1;
                        w_waddr = w_free_idx;
                        w_vset  = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        // table full, write dropped
                        n_rsp.status = 1'b1;
                    end
                end
            end
            ACT_BOUNDS: begin
                if (w_acc.any) begin
                    n_rsp.row_high = w_acc.rhi;
                    n_rsp.row_low  = w_acc.rlo;
                    n_rsp.col_high = w_acc.chi;
                    n_rsp.col_low  = w_acc.clo;
                end
            end
            default: begin
            end
        endcase
        if (r_state != S_DONE) begin
            w_we   = 1'b0;
            w_vset = 1'b0;
            w_vclr = 1'b0;
        end
        w_cnt_ext         = {{CNT_W{1'b0}}, n_count};
        n_rsp.entry_count = w_cnt_ext[CNT_W-1:0];
    end

    // valid bits, entry count, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (w_accept && i_req.action == ACT_CLEAR) begin
            r_valid <= '0;
            r_count <= '0;
            r_done  <= 1'b1;
        end else if (r_state == S_DONE) begin
            r_count <= n_count;
            r_done  <= 1'b1;
            if (w_vset) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (w_vclr) begin
                r_valid[w_hit_idx] <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_req.action == ACT_CLEAR) begin
            r_rsp <= '0;
        end else if (r_state == S_DONE) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef SYNTHESIS
    // count tracks the number of set valid bits
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count))
        else $error("entry count differs from valid bits");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("entry count above capacity");

    // a strobe comes only from a finished scan or a clear
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_DONE ||
                         (start && !busy && i_req.action == ACT_CLEAR)))
        else $error("result strobe without a finished request");

    // scanning requests hold busy
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.action != ACT_CLEAR) |=> busy && !o_done)
        else $error("scan request did not hold busy");
`endif

endmodule

>>> sv/smds_mem.sv
// entry memory: one write port, one registered read port
module smds_mem import smds_pkg::*; #(
    parameter int DEPTH = SMDS_CAPACITY,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/smds_scan.sv
// shared compare unit: matches the key and gathers bounds and the first free slot
module smds_scan import smds_pkg::*; #(
    parameter int IW = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_init,
    input  logic [ROW_W-1:0] i_row,
    input  logic [COL_W-1:0] i_col,
    input  t_stream          i_str,
    input  logic [IW-1:0]    i_idx,
    output t_acc             o_acc,
    output logic [IW-1:0]    o_hit_idx,
    output logic [IW-1:0]    o_free_idx
);

    t_acc          r_acc;
    logic [IW-1:0] r_hit_idx;
    logic [IW-1:0] r_free_idx;
    logic          w_match;

    assign w_match = (i_str.entry.row == i_row) && (i_str.entry.col == i_col);

    // control flags, then gathered data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_acc.hit     <= 1'b0;
            r_acc.any     <= 1'b0;
            r_acc.free_ok <= 1'b0;
        end else if (i_str.pv) begin
            if (i_str.valid) begin
                r_acc.any <= 1'b1;
                if (w_match) begin
                    r_acc.hit <= 1'b1;
                end
            end else begin
                r_acc.free_ok <= 1'b1;
            end
        end
        if (i_str.pv) begin
            if (i_str.valid) begin
                if (w_match && !r_acc.hit) begin
                    r_acc.hit_value <= i_str.entry.value;
                    r_hit_idx       <= i_idx;
                end
                if (!r_acc.any || i_str.entry.row > r_acc.rhi) begin
                    r_acc.rhi <= i_str.entry.row;
                end
                if (!r_acc.any || i_str.entry.row < r_acc.rlo) begin
                    r_acc.rlo <= i_str.entry.row;
                end
                if (!r_acc.any || i_str.entry.col > r_acc.chi) begin
                    r_acc.chi <= i_str.entry.col;
                end
                if (!r_acc.any || i_str.entry.col < r_acc.clo) begin
                    r_acc.clo <= i_str.entry.col;
                end
            end else if (!r_acc.free_ok) begin
                r_free_idx <= i_idx;
            end
        end
    end

    assign o_acc      = r_acc;
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;

endmodule
